// ===== rtl/rwmf_pkg.sv =====
// ----------------------------------------------------------------------------
// rwmf_pkg
// shared constants and types of the rgb window median filter
// ----------------------------------------------------------------------------
`default_nettype none

package rwmf_pkg;

  localparam int unsigned MAX_RADIUS_DEF = 3;
  localparam int unsigned MAX_WIDTH_DEF  = 1024;

  localparam int unsigned CH_W  = 8;
  localparam int unsigned PIX_W = 3 * CH_W;

  localparam int unsigned WREG_W = 11;
  localparam int unsigned HREG_W = 13;
  localparam int unsigned RREG_W = 2;
  localparam int unsigned CFG_W  = 13;
  localparam int unsigned CIDX_W = 2;

  localparam logic [CIDX_W-1:0] CFG_IMAGE_WIDTH  = 2'd0;
  localparam logic [CIDX_W-1:0] CFG_IMAGE_HEIGHT = 2'd1;
  localparam logic [CIDX_W-1:0] CFG_RADIUS       = 2'd2;

  localparam logic [WREG_W-1:0] WIDTH_RST  = 11'd640;
  localparam logic [HREG_W-1:0] HEIGHT_RST = 13'd480;
  localparam logic [RREG_W-1:0] RADIUS_RST = 2'd2;

  localparam logic KIND_PIXEL = 1'b0;

  typedef struct packed {
    logic start;
    logic acc;
    logic eval;
  } rank_ctrl_t;

endpackage

`default_nettype wire

// ===== rtl/rwmf_line_store.sv =====
// ----------------------------------------------------------------------------
// rwmf_line_store
// ring of image rows, one write and one registered read per cycle
// ----------------------------------------------------------------------------
`default_nettype none

module rwmf_line_store #(
  parameter int unsigned Rows  = 8,
  parameter int unsigned Cols  = 1024,
  parameter int unsigned RowW  = $clog2(Rows),
  parameter int unsigned ColW  = $clog2(Cols),
  parameter int unsigned DataW = 24
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [RowW-1:0]  wrow_i,
  input  wire logic [ColW-1:0]  wcol_i,
  input  wire logic [DataW-1:0] wdata_i,
  input  wire logic             re_i,
  input  wire logic [RowW-1:0]  rrow_i,
  input  wire logic [ColW-1:0]  rcol_i,
  output logic      [DataW-1:0] rdata_o
);

  logic [DataW-1:0] mem [Rows][Cols];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[wrow_i][wcol_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem[rrow_i][rcol_i];
    end
  end

endmodule

`default_nettype wire

// ===== rtl/rwmf_rank_unit.sv =====
// ----------------------------------------------------------------------------
// rwmf_rank_unit
// bitwise median search, one window value per cycle while acc is set, on all three channels
// ----------------------------------------------------------------------------
`default_nettype none

module rwmf_rank_unit #(
  parameter int unsigned CntW = 6
) (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire rwmf_pkg::rank_ctrl_t            ctrl_i,
  input  wire logic [rwmf_pkg::PIX_W-1:0]      data_i,
  input  wire logic [CntW-1:0]                 rank_i,
  output logic                                 last_o,
  output logic      [rwmf_pkg::PIX_W-1:0]      result_o
);
  import rwmf_pkg::*;

  logic [CH_W-1:0] prefix_q [3];
  logic [CntW-1:0] cnt_q    [3];
  logic [CntW-1:0] cnt_d    [3];
  logic [CH_W-1:0] thr      [3];
  logic [2:0]      bit_q;

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      thr[c]   = prefix_q[c] | (8'd1 << bit_q);
      cnt_d[c] = cnt_q[c] + CntW'(ctrl_i.acc && (data_i[(2-c)*CH_W +: CH_W] < thr[c]));
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bit_q <= 3'd7;
    end else if (ctrl_i.start) begin
      bit_q <= 3'd7;
    end else if (ctrl_i.eval) begin
      bit_q <= bit_q - 3'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    for (int c = 0; c < 3; c++) begin
      if (ctrl_i.start) begin
        prefix_q[c] <= '0;
        cnt_q[c]    <= '0;
      end else if (ctrl_i.eval) begin
        if (cnt_d[c] <= rank_i) begin
          prefix_q[c] <= thr[c];
        end
        cnt_q[c] <= '0;
      end else if (ctrl_i.acc) begin
        cnt_q[c] <= cnt_d[c];
      end
    end
  end

  assign last_o   = (bit_q == 3'd0);
  assign result_o = {prefix_q[0], prefix_q[1], prefix_q[2]};

endmodule

`default_nettype wire

// ===== rtl/rgb_window_median_filter.sv =====
// ----------------------------------------------------------------------------
// rgb_window_median_filter
// per-channel square window median over a raster stream, replicated borders
// ----------------------------------------------------------------------------
// channel  handshake               payload
// in       in_valid_i/in_stall_o   kind_i, red_in_i, green_in_i, blue_in_i
// out      out_valid_o/out_stall_i red_out_o, green_out_o, blue_out_o,
//                                  run_last_o, image_end_o
// cfg      cfg_we_i                cfg_idx_i, cfg_data_i
//
// median pixel (radius 2 or more): the rank unit reads the line store one window value
// per cycle for each of 8 bit passes; a smaller radius passes the pixel through
// pass-through: the pixel is read back from the line store; no result: no output is made
// reset clears the stream position; the line store is not cleared
// the output register lets a new input transaction in while a result waits;
// a second result waits in the done step until the output register frees
// ----------------------------------------------------------------------------
`default_nettype none

module rgb_window_median_filter #(
  parameter int unsigned MaxRadius = rwmf_pkg::MAX_RADIUS_DEF,
  parameter int unsigned MaxWidth  = rwmf_pkg::MAX_WIDTH_DEF
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          in_valid_i,
  output logic                               in_stall_o,
  input  wire logic                          kind_i,
  input  wire logic [rwmf_pkg::CH_W-1:0]     red_in_i,
  input  wire logic [rwmf_pkg::CH_W-1:0]     green_in_i,
  input  wire logic [rwmf_pkg::CH_W-1:0]     blue_in_i,
  output logic                               out_valid_o,
  input  wire logic                          out_stall_i,
  output logic      [rwmf_pkg::CH_W-1:0]     red_out_o,
  output logic      [rwmf_pkg::CH_W-1:0]     green_out_o,
  output logic      [rwmf_pkg::CH_W-1:0]     blue_out_o,
  output logic                               run_last_o,
  output logic                               image_end_o,
  input  wire logic                          cfg_we_i,
  input  wire logic [rwmf_pkg::CIDX_W-1:0]   cfg_idx_i,
  input  wire logic [rwmf_pkg::CFG_W-1:0]    cfg_data_i
);
  import rwmf_pkg::*;

  localparam int unsigned Ring = 2 * MaxRadius + 2;
  localparam int unsigned RgW  = $clog2(Ring);
  localparam int unsigned CW   = $clog2(MaxWidth);
  localparam int unsigned WW   = $clog2(MaxWidth + 1);
  localparam int unsigned TW   = WW + HREG_W;
  localparam int unsigned NW   = TW + 1;
  localparam int unsigned OfW  = $clog2(2 * MaxRadius + 1);
  localparam int unsigned CntW = $clog2((2 * MaxRadius + 1) * (2 * MaxRadius + 1) + 1);

  typedef enum logic [6:0] {
    ST_IDLE  = 7'b0000001,
    ST_CALC  = 7'b0000010,
    ST_PREAD = 7'b0000100,
    ST_SCAN  = 7'b0001000,
    ST_EVAL  = 7'b0010000,
    ST_DONE  = 7'b0100000,
    ST_SPARE = 7'b1000000
  } state_e;

  state_e state_q, state_d;

  logic [WREG_W-1:0] wreg_q;
  logic [HREG_W-1:0] hreg_q;
  logic [RREG_W-1:0] rreg_q;

  logic [WW-1:0]     w_eff;
  logic [HREG_W-1:0] h_eff;
  logic [RREG_W-1:0] r_eff;
  logic [TW-1:0]     total_q;
  logic [NW-1:0]     delay_q;
  logic [CntW-1:0]   rank_q;
  logic [CntW-1:0]   wcount;
  logic [WW-1:0]     wm1;

  logic [NW-1:0]     n_q;
  logic [CW-1:0]     in_col_q;
  logic [RgW-1:0]    in_ring_q;
  logic [CW-1:0]     ox_q;
  logic [HREG_W-1:0] oy_q;
  logic [RgW-1:0]    out_ring_q;
  logic [OfW-1:0]    ix_q, iy_q;
  logic              acc_q;
  logic              pass_q;
  logic              last_q;
  logic              kind_q;
  logic [PIX_W-1:0]  pix_q;

  logic [NW-1:0]     m;
  logic              in_image, produce, wr_en;
  logic              advance_in, advance_out, clear_pos, load_out;
  logic              win_last;
  logic              cfg_hit;

  logic signed [15:0] yy, ycl, dyc, rg, xx, xcl;
  logic [RgW-1:0]     rd_row;
  logic [CW-1:0]      rd_col;
  logic               rd_en;
  logic [PIX_W-1:0]   rd_data;

  rank_ctrl_t        rctrl;
  logic              rank_last;
  logic [PIX_W-1:0]  rank_res;

  logic              out_valid_q;
  logic [PIX_W-1:0]  out_px_q;
  logic              out_end_q;

  // effective register values
  always_comb begin
    if (wreg_q == '0) begin
      w_eff = WW'(1);
    end else if (32'(wreg_q) > MaxWidth) begin
      w_eff = WW'(MaxWidth);
    end else begin
      w_eff = WW'(wreg_q);
    end
    h_eff  = (hreg_q == '0) ? HREG_W'(1) : hreg_q;
    r_eff  = (32'(rreg_q) > MaxRadius) ? RREG_W'(MaxRadius) : rreg_q;
    wm1    = w_eff - WW'(1);
    wcount = CntW'((2 * 32'(r_eff) + 1) * (2 * 32'(r_eff) + 1));
  end

  always_ff @(posedge clk_i) begin
    total_q <= TW'(w_eff) * TW'(h_eff);
    if (r_eff >= RREG_W'(2)) begin
      delay_q <= NW'(r_eff) * NW'(w_eff) + NW'((WW'(r_eff) < wm1) ? WW'(r_eff) : wm1);
    end else begin
      delay_q <= '0;
    end
    rank_q <= wcount >> 1;
  end

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wreg_q <= WIDTH_RST;
      hreg_q <= HEIGHT_RST;
      rreg_q <= RADIUS_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_IMAGE_WIDTH:  wreg_q <= cfg_data_i[WREG_W-1:0];
        CFG_IMAGE_HEIGHT: hreg_q <= cfg_data_i[HREG_W-1:0];
        CFG_RADIUS:       rreg_q <= cfg_data_i[RREG_W-1:0];
        default: ;
      endcase
    end
  end

  assign cfg_hit = cfg_we_i && ((cfg_idx_i == CFG_IMAGE_WIDTH) ||
                                (cfg_idx_i == CFG_IMAGE_HEIGHT) ||
                                (cfg_idx_i == CFG_RADIUS));

  // stream position decisions
  assign m        = n_q - delay_q;
  assign in_image = (n_q < NW'(total_q));
  assign produce  = (n_q >= delay_q) && (m < NW'(total_q));
  assign wr_en    = (state_q == ST_CALC) && in_image && (kind_q == KIND_PIXEL);
  assign win_last = (ix_q == OfW'(2 * r_eff)) && (iy_q == OfW'(2 * r_eff));
  assign load_out = (state_q == ST_DONE) && (!out_valid_q || !out_stall_i);

  always_comb begin
    state_d     = state_q;
    advance_in  = 1'b0;
    advance_out = 1'b0;
    clear_pos   = 1'b0;
    rctrl       = '0;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          state_d = ST_CALC;
        end
      end
      ST_CALC: begin
        if (in_image && kind_q != KIND_PIXEL) begin
          state_d = ST_IDLE;
        end else if (!produce) begin
          advance_in = 1'b1;
          state_d    = ST_IDLE;
        end else if (r_eff < RREG_W'(2)) begin
          state_d = ST_PREAD;
        end else begin
          rctrl.start = 1'b1;
          state_d     = ST_SCAN;
        end
      end
      ST_PREAD: state_d = ST_DONE;
      ST_SCAN: begin
        rctrl.acc = acc_q;
        if (win_last) begin
          state_d = ST_EVAL;
        end
      end
      ST_EVAL: begin
        rctrl.acc  = acc_q;
        rctrl.eval = 1'b1;
        state_d    = rank_last ? ST_DONE : ST_SCAN;
      end
      ST_DONE: begin
        if (load_out) begin
          if (last_q) begin
            clear_pos = 1'b1;
          end else begin
            advance_in  = 1'b1;
            advance_out = 1'b1;
          end
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      n_q        <= '0;
      in_col_q   <= '0;
      in_ring_q  <= '0;
      ox_q       <= '0;
      oy_q       <= '0;
      out_ring_q <= '0;
      ix_q       <= '0;
      iy_q       <= '0;
      acc_q      <= 1'b0;
    end else begin
      state_q <= state_d;
      acc_q   <= (state_q == ST_SCAN);
      if (cfg_hit || clear_pos) begin
        n_q        <= '0;
        in_col_q   <= '0;
        in_ring_q  <= '0;
        ox_q       <= '0;
        oy_q       <= '0;
        out_ring_q <= '0;
      end else begin
        if (advance_in) begin
          n_q <= n_q + NW'(1);
          if (WW'(in_col_q) == wm1) begin
            in_col_q  <= '0;
            in_ring_q <= (in_ring_q == RgW'(Ring - 1)) ? '0 : in_ring_q + RgW'(1);
          end else begin
            in_col_q <= in_col_q + CW'(1);
          end
        end
        if (advance_out) begin
          if (WW'(ox_q) == wm1) begin
            ox_q       <= '0;
            oy_q       <= oy_q + HREG_W'(1);
            out_ring_q <= (out_ring_q == RgW'(Ring - 1)) ? '0 : out_ring_q + RgW'(1);
          end else begin
            ox_q <= ox_q + CW'(1);
          end
        end
      end
      if (state_q == ST_SCAN) begin
        if (ix_q == OfW'(2 * r_eff)) begin
          ix_q <= '0;
          iy_q <= win_last ? '0 : iy_q + OfW'(1);
        end else begin
          ix_q <= ix_q + OfW'(1);
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == ST_IDLE) begin
      kind_q <= kind_i;
      pix_q  <= {red_in_i, green_in_i, blue_in_i};
    end
    if (state_q == ST_CALC) begin
      pass_q <= (r_eff < RREG_W'(2));
      last_q <= (m == NW'(total_q) - NW'(1));
    end
  end

  // window address with clamped borders
  always_comb begin
    yy  = $signed({3'b0, oy_q}) + $signed(16'(iy_q)) - $signed(16'(r_eff));
    if (yy < 16'sd0) begin
      ycl = 16'sd0;
    end else if (yy > $signed(16'(h_eff) - 16'd1)) begin
      ycl = $signed(16'(h_eff) - 16'd1);
    end else begin
      ycl = yy;
    end
    dyc = ycl - $signed({3'b0, oy_q});
    rg  = $signed(16'(out_ring_q)) + dyc;
    if (rg < 16'sd0) begin
      rg = rg + $signed(16'(Ring));
    end else if (rg >= $signed(16'(Ring))) begin
      rg = rg - $signed(16'(Ring));
    end
    xx = $signed(16'(ox_q)) + $signed(16'(ix_q)) - $signed(16'(r_eff));
    if (xx < 16'sd0) begin
      xcl = 16'sd0;
    end else if (xx > $signed(16'(wm1))) begin
      xcl = $signed(16'(wm1));
    end else begin
      xcl = xx;
    end
    if (state_q == ST_PREAD) begin
      rd_row = out_ring_q;
      rd_col = ox_q;
    end else begin
      rd_row = RgW'(rg);
      rd_col = CW'(xcl);
    end
    rd_en = (state_q == ST_PREAD) || (state_q == ST_SCAN);
  end

  rwmf_line_store #(
    .Rows  (Ring),
    .Cols  (MaxWidth),
    .RowW  (RgW),
    .ColW  (CW),
    .DataW (PIX_W)
  ) u_line_store (
    .clk_i   (clk_i),
    .we_i    (wr_en),
    .wrow_i  (in_ring_q),
    .wcol_i  (in_col_q),
    .wdata_i (pix_q),
    .re_i    (rd_en),
    .rrow_i  (rd_row),
    .rcol_i  (rd_col),
    .rdata_o (rd_data)
  );

  rwmf_rank_unit #(
    .CntW (CntW)
  ) u_rank_unit (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .ctrl_i   (rctrl),
    .data_i   (rd_data),
    .rank_i   (rank_q),
    .last_o   (rank_last),
    .result_o (rank_res)
  );

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (load_out) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_out) begin
      out_px_q  <= pass_q ? rd_data : rank_res;
      out_end_q <= last_q;
    end
  end

  assign in_stall_o  = (state_q != ST_IDLE);
  assign out_valid_o = out_valid_q;
  assign red_out_o   = out_px_q[23:16];
  assign green_out_o = out_px_q[15:8];
  assign blue_out_o  = out_px_q[7:0];
  assign run_last_o  = 1'b1;
  assign image_end_o = out_end_q;

  // a transaction is taken only from idle and always goes to the decision step
  a_accept_calc: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> (state_q == ST_CALC))
    else $error("accepted transaction did not reach decision step");

  // the line store is written only during the decision step
  a_write_calc: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wr_en |-> (state_q == ST_CALC))
    else $error("line store write outside decision step");

  // a new result never overwrites one still waiting
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_stall_i) |=> (out_valid_q && $stable(out_px_q)))
    else $error("waiting result overwritten");

  // the rank evaluation only follows a full window scan
  a_eval_after_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_EVAL) |-> ($past(state_q) == ST_SCAN))
    else $error("evaluation without scan");

endmodule

`default_nettype wire
